// ----- hdl/bdq_pkg.sv -----
package bdq_pkg;

   localparam int DEPTH_DEF      = 64;
   localparam int ITEM_WIDTH_DEF = 32;

   localparam logic [3:0] KIND_APPEND_TAIL   = 4'd0;
   localparam logic [3:0] KIND_INSERT_HEAD   = 4'd1;
   localparam logic [3:0] KIND_APPEND_UNIQUE = 4'd2;
   localparam logic [3:0] KIND_POP_TAIL      = 4'd3;
   localparam logic [3:0] KIND_POP_HEAD      = 4'd4;
   localparam logic [3:0] KIND_REMOVE_VALUE  = 4'd5;
   localparam logic [3:0] KIND_READ_NTH      = 4'd6;
   localparam logic [3:0] KIND_PEEK_TAIL     = 4'd7;
   localparam logic [3:0] KIND_CLEAR         = 4'd8;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_EMPTY = 2'd1;
   localparam logic [1:0] ERR_INDEX = 2'd2;
   localparam logic [1:0] ERR_FULL  = 2'd3;

   typedef struct packed {
      logic [3:0]  kind;
      logic [31:0] item_value;
      logic [5:0]  position;
   } req_type;

   typedef struct packed {
      logic [31:0] value_out;
      logic        success;
      logic [1:0]  error_code;
      logic [6:0]  entry_count;
   } rsp_type;

endpackage

// ----- hdl/bdq_ram.sv -----
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/bdq_ctrl.sv -----
module bdq_ctrl #(
   parameter int DEPTH      = 64,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  bdq_pkg::req_type         req_data,
   output logic                     req_stall,
   input  logic                     out_free,
   output logic                     done,
   output bdq_pkg::rsp_type         result,
   output logic                     wr_en,
   output logic [$clog2(DEPTH)-1:0] wr_addr,
   output logic [ITEM_WIDTH-1:0]    wr_data,
   output logic                     rd_en,
   output logic [$clog2(DEPTH)-1:0] rd_addr,
   input  logic [ITEM_WIDTH-1:0]    rd_data
);
   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN_RD  = 3'd1;
   localparam logic [2:0] S_SCAN_CMP = 3'd2;
   localparam logic [2:0] S_SH_RD    = 3'd3;
   localparam logic [2:0] S_SH_WR    = 3'd4;
   localparam logic [2:0] S_RD_WAIT  = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [3:0]            kind_ff, kind_in;
   logic [ITEM_WIDTH-1:0] item_ff, item_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         occ_ff, occ_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [31:0]           val_ff, val_in;
   logic                  ok_ff, ok_in;
   logic [1:0]            err_ff, err_in;

   logic [63:0]           req_wide;
   logic [63:0]           rd_wide;
   logic [31:0]           occ_wide;
   logic                  full;
   logic                  empty;
   logic [AW-1:0]         head_prev;
   logic [XW-1:0]         idx_next;
   logic [XW-1:0]         idx_next2;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] k);
      logic [XW-1:0] s;
      s = XW'(head) + XW'(k);
      if (s >= XW'(DEPTH)) begin
         s = s - XW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   assign req_wide  = 64'(req_data.item_value);
   assign rd_wide   = 64'(rd_data);
   assign occ_wide  = 32'(occ_ff);
   assign full      = (occ_ff == CW'(DEPTH));
   assign empty     = (occ_ff == '0);
   assign head_prev = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign idx_next  = XW'(idx_ff) + XW'(1);
   assign idx_next2 = XW'(idx_ff) + XW'(2);

   assign req_stall = (state_ff != S_IDLE);
   assign done      = (state_ff == S_DONE) && out_free;

   assign result.value_out   = val_ff;
   assign result.success     = ok_ff;
   assign result.error_code  = err_ff;
   assign result.entry_count = occ_wide[6:0];

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      item_in  = item_ff;
      head_in  = head_ff;
      occ_in   = occ_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      ok_in    = ok_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      wr_addr  = slot_of(head_ff, occ_ff);
      wr_data  = item_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_data.kind;
               item_in  = req_wide[ITEM_WIDTH-1:0];
               idx_in   = '0;
               val_in   = '0;
               ok_in    = 1'b0;
               err_in   = ERR_NONE;
               state_in = S_DONE;
               case (req_data.kind)
                  KIND_APPEND_TAIL: begin
                     if (full) begin
                        err_in = ERR_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = req_wide[ITEM_WIDTH-1:0];
                        occ_in  = occ_ff + CW'(1);
                        ok_in   = 1'b1;
                     end
                  end
                  KIND_INSERT_HEAD: begin
                     if (full) begin
                        err_in = ERR_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = head_prev;
                        wr_data = req_wide[ITEM_WIDTH-1:0];
                        head_in = head_prev;
                        occ_in  = occ_ff + CW'(1);
                        ok_in   = 1'b1;
                     end
                  end
                  KIND_APPEND_UNIQUE, KIND_REMOVE_VALUE: begin
                     state_in = S_SCAN_RD;
                  end
                  KIND_POP_TAIL, KIND_PEEK_TAIL: begin
                     if (empty) begin
                        err_in = ERR_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(head_ff, occ_ff - CW'(1));
                        state_in = S_RD_WAIT;
                        if (req_data.kind == KIND_POP_TAIL) begin
                           occ_in = occ_ff - CW'(1);
                        end
                     end
                  end
                  KIND_POP_HEAD: begin
                     if (empty) begin
                        err_in = ERR_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = slot_of(head_ff, CW'(1));
                        occ_in   = occ_ff - CW'(1);
                        state_in = S_RD_WAIT;
                     end
                  end
                  KIND_READ_NTH: begin
                     if (empty) begin
                        err_in = ERR_EMPTY;
                     end else if (32'(req_data.position) >= occ_wide) begin
                        err_in = ERR_INDEX;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = slot_of(head_ff, CW'(req_data.position));
                        state_in = S_RD_WAIT;
                     end
                  end
                  KIND_CLEAR: begin
                     head_in = '0;
                     occ_in  = '0;
                     ok_in   = 1'b1;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            if (idx_ff == occ_ff) begin
               // handle absent: unique appends, remove reports a miss
               state_in = S_DONE;
               if (kind_ff == KIND_APPEND_UNIQUE) begin
                  if (full) begin
                     err_in = ERR_FULL;
                  end else begin
                     wr_en  = 1'b1;
                     occ_in = occ_ff + CW'(1);
                     ok_in  = 1'b1;
                  end
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = slot_of(head_ff, idx_ff);
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (rd_data == item_ff) begin
               if (kind_ff == KIND_APPEND_UNIQUE) begin
                  state_in = S_DONE;
               end else if (idx_next < XW'(occ_ff)) begin
                  state_in = S_SH_RD;
               end else begin
                  occ_in   = occ_ff - CW'(1);
                  ok_in    = 1'b1;
                  state_in = S_DONE;
               end
            end else begin
               idx_in   = idx_next[CW-1:0];
               state_in = S_SCAN_RD;
            end
         end
         S_SH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_of(head_ff, idx_next[CW-1:0]);
            state_in = S_SH_WR;
         end
         S_SH_WR: begin
            // close the gap one entry at a time
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, idx_ff);
            wr_data = rd_data;
            idx_in  = idx_next[CW-1:0];
            if (idx_next2 < XW'(occ_ff)) begin
               state_in = S_SH_RD;
            end else begin
               occ_in   = occ_ff - CW'(1);
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_RD_WAIT: begin
            val_in   = rd_wide[31:0];
            ok_in    = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
      end
      kind_ff <= kind_in;
      item_ff <= item_in;
      idx_ff  <= idx_in;
      val_ff  <= val_in;
      ok_ff   <= ok_in;
      err_ff  <= err_in;
   end
endmodule

// ----- hdl/bounded_deque_with_search.sv -----
// Channel   Ports                         Beat
// request   req_valid req_stall req_data  one command (kind, item_value, position)
// response  rsp_valid rsp_stall rsp_data  one result per command
//
// Append, insert, clear and rejected commands go straight to the done state;
// pops, peek and read nth first wait in a state for the registered memory read.
// Append unique and remove value scan the held entries, reading then comparing
// each; remove then closes the gap, reading and rewriting each later entry.
// Synchronous reset empties the store; entry memory is not cleared.
// A stalled response waits in its register; the next command is taken meanwhile.
module bounded_deque_with_search #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
   parameter int ITEM_WIDTH = bdq_pkg::ITEM_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;
   logic                  out_free;
   logic                  done;
   rsp_type               result;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   bdq_ctrl #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .out_free  (out_free),
      .done      (done),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   bdq_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid_in = done || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = done ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ----- bench/bdq_checker.sv -----
module bdq_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bdq_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bdq_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import bdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEPTH_DEF;

   logic [31:0] slots [DEPTH];
   logic [5:0]  head;
   int          held;
   rsp_type     want_q [$];

   assign pending = want_q.size();

   function automatic logic [5:0] slot_at(int k);
      return 6'((int'(head) + k) % DEPTH);
   endfunction

   function automatic rsp_type apply_command(req_type c);
      rsp_type r;
      bit      hit;
      int      k;
      r = '0;
      hit = 0;
      case (c.kind)
         KIND_APPEND_TAIL, KIND_APPEND_UNIQUE: begin
            if (c.kind == KIND_APPEND_UNIQUE)
               for (k = 0; k < held; k++)
                  if (slots[slot_at(k)] == c.item_value) hit = 1;
            if (!hit) begin
               if (held >= DEPTH) r.error_code = ERR_FULL;
               else begin
                  slots[slot_at(held)] = c.item_value;
                  held++;
                  r.success = 1;
               end
            end
         end
         KIND_INSERT_HEAD: begin
            if (held >= DEPTH) r.error_code = ERR_FULL;
            else begin
               head = slot_at(DEPTH - 1);
               slots[head] = c.item_value;
               held++;
               r.success = 1;
            end
         end
         KIND_POP_TAIL, KIND_PEEK_TAIL: begin
            if (held == 0) r.error_code = ERR_EMPTY;
            else begin
               r.value_out = slots[slot_at(held - 1)];
               if (c.kind == KIND_POP_TAIL) held--;
               r.success = 1;
            end
         end
         KIND_POP_HEAD: begin
            if (held == 0) r.error_code = ERR_EMPTY;
            else begin
               r.value_out = slots[head];
               head = slot_at(1);
               held--;
               r.success = 1;
            end
         end
         KIND_REMOVE_VALUE: begin
            for (k = 0; k < held && !hit; k++)
               if (slots[slot_at(k)] == c.item_value) begin
                  hit = 1;
                  for (int j = k; j + 1 < held; j++)
                     slots[slot_at(j)] = slots[slot_at(j + 1)];
               end
            if (hit) begin
               held--;
               r.success = 1;
            end
         end
         KIND_READ_NTH: begin
            if (held == 0) r.error_code = ERR_EMPTY;
            else if (int'(c.position) >= held) r.error_code = ERR_INDEX;
            else begin
               r.value_out = slots[slot_at(int'(c.position))];
               r.success = 1;
            end
         end
         KIND_CLEAR: begin
            head = '0;
            held = 0;
            r.success = 1;
         end
         default: ;
      endcase
      r.entry_count = 7'(held);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type w;
      if (reset) begin
         head = '0;
         held = 0;
         fail_count <= 0;
         want_q.delete();
      end else begin
         if (req_valid && !req_stall)
            want_q.push_back(apply_command(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (want_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               w = want_q.pop_front();
               if (w != rsp_data) begin
                  if (fail_count < 10)
                     $display("mismatch: exp val=%h ok=%b err=%0d cnt=%0d",
                        w.value_out, w.success, w.error_code, w.entry_count,
                        " got val=%h ok=%b err=%0d cnt=%0d",
                        rsp_data.value_out, rsp_data.success, rsp_data.error_code,
                        rsp_data.entry_count);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- bench/tb_top.sv -----
module tb_top;
   import bdq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      cycles = 0;
   int      quiet_span = 0;
   int      hold_span = 0;
   logic [31:0] pool [8];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   bounded_deque_with_search dut (.*);

   bdq_checker chk (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // receiver: random stall, a long hold-off, and an idle-free stretch
   always @(posedge clock) begin
      if (hold_span > 0) begin
         hold_span <= hold_span - 1;
         rsp_stall <= 1;
      end else if (quiet_span > 0)
         rsp_stall <= 0;
      else
         rsp_stall <= ($urandom_range(99) < 20);
   end

   task automatic send(req_type c);
      req_data <= c;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      if (quiet_span == 0 && $urandom_range(99) < 20) begin
         req_valid <= 0;
         repeat ($urandom_range(4)) @(posedge clock);
      end
   endtask

   function automatic req_type cmd(logic [3:0] k, logic [31:0] v, logic [5:0] p);
      req_type c;
      c.kind = k;
      c.item_value = v;
      c.position = p;
      return c;
   endfunction

   function automatic req_type random_cmd(int fill_bias);
      logic [3:0]  k;
      logic [31:0] v;
      int          r;
      r = $urandom_range(99);
      if (r < fill_bias) k = 4'($urandom_range(2));
      else if (r < 97) k = 4'($urandom_range(3, 7));
      else if (r < 99) k = KIND_CLEAR;
      else k = 4'($urandom_range(9, 15));
      v = ($urandom_range(3) == 0) ? $urandom : pool[$urandom_range(7)];
      return cmd(k, v, 6'($urandom));
   endfunction

   task automatic drain;
      req_valid <= 0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      foreach (pool[i]) pool[i] = $urandom;
      pool[0] = '0;
      pool[1] = '1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // empty-store errors, then extremes and every operation
      send(cmd(KIND_POP_TAIL, '0, '0));
      send(cmd(KIND_POP_HEAD, '0, '0));
      send(cmd(KIND_READ_NTH, '0, '0));
      send(cmd(KIND_PEEK_TAIL, '0, '0));
      send(cmd(KIND_REMOVE_VALUE, 32'd5, '0));
      send(cmd(KIND_APPEND_TAIL, 32'h0, '0));
      send(cmd(KIND_INSERT_HEAD, 32'hFFFF_FFFF, '0));
      send(cmd(KIND_APPEND_UNIQUE, 32'h0, '0));
      send(cmd(KIND_APPEND_UNIQUE, 32'h1234_5678, '0));
      send(cmd(KIND_READ_NTH, '0, 6'd63));
      send(cmd(KIND_READ_NTH, '0, 6'd1));
      send(cmd(KIND_PEEK_TAIL, '0, '0));
      send(cmd(KIND_REMOVE_VALUE, 32'h0, '0));
      send(cmd(KIND_POP_HEAD, '0, '0));
      send(cmd(KIND_POP_TAIL, '0, '0));
      send(cmd(4'd9, 32'hA5A5_A5A5, 6'd63));
      send(cmd(4'd15, '0, '0));
      send(cmd(KIND_CLEAR, '0, '0));
      drain();
      // fill under a long receiver hold-off until full errors show up
      hold_span <= 300;
      for (int i = 0; i < 70; i++)
         send(cmd(KIND_APPEND_TAIL, $urandom, 6'($urandom)));
      send(cmd(KIND_INSERT_HEAD, 32'hDEAD_BEEF, '0));
      send(cmd(KIND_APPEND_UNIQUE, 32'hC0DE_0001, '0));
      send(cmd(KIND_READ_NTH, '0, 6'd63));
      drain();
      for (int i = 0; i < 500; i++) begin
         if (i == 200) quiet_span <= 0;
         if (i >= 150 && i < 200) quiet_span <= 1;
         if (i == 300) drain();
         send(random_cmd((i % 160 < 80) ? 55 : 35));
      end
      drain();
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
